@@ hdl/fx8dt_pkg.sv @@
package fx8dt_pkg;

    // Number format: signed value with eight fraction bits.
    localparam int VALUE_W = 32;
    localparam int FRAC_BITS = 8;
    localparam int MAG_W = VALUE_W - 1;
    localparam int INT_W = MAG_W - FRAC_BITS + 1;

    // Fraction scaling to four decimal places, rounded half-up.
    localparam int FRAC_ONE = 256;
    localparam int FRAC_DEC = 10000;
    localparam int FRAC_HALF = FRAC_ONE / 2;
    localparam int FRAC_W = 14;
    localparam int PROD_W = FRAC_W + FRAC_BITS;

    // Packed BCD working register of the shared conversion unit.
    localparam int BCD_DIGITS = 8;
    localparam int BCD_W = 4 * BCD_DIGITS;
    localparam int FRAC_DIGITS = 4;
    localparam int FRAC_BCD_W = 4 * FRAC_DIGITS;

    // Character codes.
    localparam int CHAR_W = 7;
    localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_INT,
        ST_FRAC,
        ST_SKIP,
        ST_MINUS,
        ST_DIGIT,
        ST_DOT,
        ST_FDIGIT,
        ST_SPACE
    } state_t;

endpackage

@@ hdl/fx8dt_dabble.sv @@
module fx8dt_dabble (
    input  logic [fx8dt_pkg::BCD_W-1:0] bcd,
    input  logic                        bit_in,
    output logic [fx8dt_pkg::BCD_W-1:0] bcd_shifted
);
    import fx8dt_pkg::*;

    logic [BCD_W-1:0] corrected;

    // Add three to every digit of five or more, then shift the next binary bit in.
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd[4*i +: 4] >= 4'd5)
            begin
                corrected[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
            else
            begin
                corrected[4*i +: 4] = bcd[4*i +: 4];
            end
        end
    end

    assign bcd_shifted = {corrected[BCD_W-2:0], bit_in};

endmodule

@@ hdl/fixed_8frac_to_decimal_text_core.sv @@
// Converts a signed 32-bit value with eight fraction bits into ASCII text, one
// character per item on char_code, marked by valid for a single cycle, with last
// on the final character; the receiver cannot stall, so characters leave one per
// cycle once emission starts. An item is taken when start is high and busy is
// low. After acceptance the block scales the fraction, converts the 24-bit integer
// part and then the 14-bit fraction, both through one shared shift-and-add-3 unit,
// strips leading zeros one digit at a time (up to 7), then emits the characters
// (1 to 14). The number of leading zeros stripped plus the number of integer digits
// is always eight. The most negative input is taken as -2147483647 units and prints
// as -8388607.9961.
module fixed_8frac_to_decimal_text_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [fx8dt_pkg::VALUE_W-1:0] value,
    input  logic                                append_space,
    output logic                                valid,
    output logic [fx8dt_pkg::CHAR_W-1:0]        char_code,
    output logic                                last
);
    import fx8dt_pkg::*;

    state_t state_reg, state_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic neg_reg, neg_next;
    logic space_reg, space_next;
    logic [INT_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [BCD_W-1:0] int_bcd_reg, int_bcd_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [FRAC_BCD_W-1:0] frac_bcd_reg, frac_bcd_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [3:0] int_left_reg, int_left_next;
    logic [2:0] frac_left_reg, frac_left_next;
    logic valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic last_reg, last_next;

    logic accept;
    logic [VALUE_W-1:0] sat_value;
    logic [VALUE_W-1:0] abs_value;
    logic [PROD_W-1:0] prod;
    logic [FRAC_W-1:0] frac_round;
    logic frac_carry;
    logic [BCD_W-1:0] unit_out;
    logic has_frac;
    logic [2:0] frac_keep;

    assign accept = start && (state_reg == ST_IDLE);

    // Shared BCD conversion unit.
    fx8dt_dabble u_dabble (
        .bcd         (bcd_reg),
        .bit_in      (bin_reg[INT_W-1]),
        .bcd_shifted (unit_out)
    );

    // Magnitude with the most negative value saturated.
    always_comb
    begin
        sat_value = value;
        if (value == {1'b1, {(VALUE_W-1){1'b0}}})
        begin
            sat_value = {1'b1, {(VALUE_W-2){1'b0}}, 1'b1};
        end
        abs_value = value[VALUE_W-1] ? (~sat_value + VALUE_W'(1)) : sat_value;
    end

    // Fraction scaled to ten thousandths, rounded half-up.
    always_comb
    begin
        prod = PROD_W'(mag_reg[FRAC_BITS-1:0]) * PROD_W'(FRAC_DEC) + PROD_W'(FRAC_HALF);
        frac_round = prod[PROD_W-1:FRAC_BITS];
        frac_carry = (frac_round == FRAC_W'(FRAC_DEC));
    end

    // Number of fraction digits left after trimming trailing zeros.
    always_comb
    begin
        has_frac = (frac_reg != '0);
        if (frac_bcd_reg[3:0] != 4'd0)
        begin
            frac_keep = 3'd4;
        end
        else if (frac_bcd_reg[7:4] != 4'd0)
        begin
            frac_keep = 3'd3;
        end
        else if (frac_bcd_reg[11:8] != 4'd0)
        begin
            frac_keep = 3'd2;
        end
        else
        begin
            frac_keep = 3'd1;
        end
    end

    // Sequencer: next state and register updates.
    always_comb
    begin
        state_next = state_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        space_next = space_reg;
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        int_bcd_next = int_bcd_reg;
        frac_next = frac_reg;
        frac_bcd_next = frac_bcd_reg;
        cnt_next = cnt_reg;
        int_left_next = int_left_reg;
        frac_left_next = frac_left_reg;
        valid_next = 1'b0;
        char_next = char_reg;
        last_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mag_next = abs_value[MAG_W-1:0];
                    neg_next = value[VALUE_W-1];
                    space_next = append_space;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                bin_next = INT_W'(mag_reg[MAG_W-1:FRAC_BITS]) + INT_W'(frac_carry);
                frac_next = frac_carry ? '0 : frac_round;
                bcd_next = '0;
                cnt_next = 5'(INT_W - 1);
                state_next = ST_INT;
            end
            ST_INT:
            begin
                bcd_next = unit_out;
                bin_next = {bin_reg[INT_W-2:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    int_bcd_next = unit_out;
                    bcd_next = '0;
                    bin_next = {frac_reg, {(INT_W-FRAC_W){1'b0}}};
                    cnt_next = 5'(FRAC_W - 1);
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                bcd_next = unit_out;
                bin_next = {bin_reg[INT_W-2:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    frac_bcd_next = unit_out[FRAC_BCD_W-1:0];
                    int_left_next = 4'(BCD_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Strip leading zeros one digit per cycle, keeping at least one.
                frac_left_next = frac_keep;
                if ((int_bcd_reg[BCD_W-1 -: 4] == 4'd0) && (int_left_reg > 4'd1))
                begin
                    int_bcd_next = {int_bcd_reg[BCD_W-5:0], 4'd0};
                    int_left_next = int_left_reg - 4'd1;
                end
                else
                begin
                    state_next = neg_reg ? ST_MINUS : ST_DIGIT;
                end
            end
            ST_MINUS:
            begin
                valid_next = 1'b1;
                char_next = CH_MINUS;
                state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                valid_next = 1'b1;
                char_next = CH_ZERO + CHAR_W'(int_bcd_reg[BCD_W-1 -: 4]);
                int_bcd_next = {int_bcd_reg[BCD_W-5:0], 4'd0};
                int_left_next = int_left_reg - 4'd1;
                if (int_left_reg == 4'd1)
                begin
                    if (has_frac)
                    begin
                        state_next = ST_DOT;
                    end
                    else if (space_reg)
                    begin
                        state_next = ST_SPACE;
                    end
                    else
                    begin
                        last_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DOT:
            begin
                valid_next = 1'b1;
                char_next = CH_DOT;
                state_next = ST_FDIGIT;
            end
            ST_FDIGIT:
            begin
                valid_next = 1'b1;
                char_next = CH_ZERO + CHAR_W'(frac_bcd_reg[FRAC_BCD_W-1 -: 4]);
                frac_bcd_next = {frac_bcd_reg[FRAC_BCD_W-5:0], 4'd0};
                frac_left_next = frac_left_reg - 3'd1;
                if (frac_left_reg == 3'd1)
                begin
                    if (space_reg)
                    begin
                        state_next = ST_SPACE;
                    end
                    else
                    begin
                        last_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SPACE:
            begin
                valid_next = 1'b1;
                char_next = CH_SPACE;
                last_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            last_reg <= 1'b0;
            cnt_reg <= '0;
            int_left_reg <= '0;
            frac_left_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            last_reg <= last_next;
            cnt_reg <= cnt_next;
            int_left_reg <= int_left_next;
            frac_left_reg <= frac_left_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        space_reg <= space_next;
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        int_bcd_reg <= int_bcd_next;
        frac_reg <= frac_next;
        frac_bcd_reg <= frac_bcd_next;
        char_reg <= char_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign valid = valid_reg;
    assign char_code = char_reg;
    assign last = last_reg;

    // An accepted item keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // The final character of an item is not followed by another in the next cycle.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last) |=> !valid)
        else $error("character emitted straight after the final one");

    // A character other than the final one is only shown while the item is in progress.
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last) |-> busy)
        else $error("non-final character shown while idle");

    // The last flag is only raised together with a character.
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> valid)
        else $error("last raised without a character");

endmodule
